>>> sv/bankers_resource_allocator_macros.svh
// assertion macros for the allocator
`ifndef BANKERS_RESOURCE_ALLOCATOR_MACROS_SVH
`define BANKERS_RESOURCE_ALLOCATOR_MACROS_SVH

`ifndef SYNTH

`define BRA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

`define BRA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`else

`define BRA_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define BRA_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> sv/bra_pkg.sv
package bra_pkg;

  localparam int OP_W        = 2;
  localparam int CUST_W      = 3;
  localparam int AMT_W       = 8;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int NUM_AMOUNTS = 5;

  localparam logic [OP_W-1:0] OP_DECLARE = 2'd0;
  localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_UNSAFE = 2'd1,
    STAT_RANGE  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    LC_IDLE,
    LC_DECLARE,
    LC_GRANT,
    LC_ADD,
    LC_RETURN
  } lane_cmd_t;

  typedef struct packed {
    logic decl_bad;
    logic over_need;
    logic over_avail;
    logic rel_bad;
    logic need_fits;
  } lane_flags_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_CHECK,
    CS_SCAN,
    CS_ROLLBACK,
    CS_DONE
  } ctrl_state_t;

endpackage

>>> sv/bra_ifs.sv
interface bra_in_if;
  import bra_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CUST_W-1:0] customer;
  logic [AMT_W-1:0]  amount_0;
  logic [AMT_W-1:0]  amount_1;
  logic [AMT_W-1:0]  amount_2;
  logic [AMT_W-1:0]  amount_3;
  logic [AMT_W-1:0]  amount_4;

  modport source (output valid, op, customer, amount_0, amount_1, amount_2, amount_3,
                  amount_4, input ready);
  modport sink (input valid, op, customer, amount_0, amount_1, amount_2, amount_3,
                amount_4, output ready);
endinterface

interface bra_out_if;
  import bra_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;

  modport source (output valid, status, input ready);
  modport sink (input valid, status, output ready);
endinterface

interface bra_cfg_if;
  import bra_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/bra_lane.sv
module bra_lane #(
  parameter int CUSTOMERS  = 5,
  parameter int COUNT_BITS = 8,
  parameter int CI_W       = 3,
  parameter int WORK_W     = 11
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [COUNT_BITS-1:0]   cfg_val,
  input  logic [bra_pkg::AMT_W-1:0] amt,
  input  bra_pkg::lane_cmd_t      cmd,
  input  logic [CI_W-1:0]         rd_idx,
  output bra_pkg::lane_flags_t    flags
);
  import bra_pkg::*;

  localparam int CMP_W = (COUNT_BITS > AMT_W) ? COUNT_BITS : AMT_W;
  localparam logic [CMP_W:0] MASK_X = {{(CMP_W + 1 - COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

  logic [COUNT_BITS-1:0] total_r;
  logic [COUNT_BITS-1:0] avail_r, avail_nxt;
  logic [WORK_W-1:0]     work_r, work_nxt;
  logic [COUNT_BITS-1:0] held_r [CUSTOMERS];
  logic [COUNT_BITS-1:0] need_r [CUSTOMERS];
  logic [COUNT_BITS-1:0] held_nxt, need_nxt;
  logic [COUNT_BITS-1:0] held_rd, need_rd, amt_c;
  logic [CMP_W-1:0]      amt_x, held_x, need_x, avail_x, total_x;
  logic                  idx_ok, wr_en;

  assign idx_ok  = 32'(rd_idx) < 32'(CUSTOMERS);
  assign held_rd = idx_ok ? held_r[rd_idx] : '0;
  assign need_rd = idx_ok ? need_r[rd_idx] : '0;

  assign amt_x   = CMP_W'(amt);
  assign held_x  = CMP_W'(held_rd);
  assign need_x  = CMP_W'(need_rd);
  assign avail_x = CMP_W'(avail_r);
  assign total_x = CMP_W'(total_r);
  assign amt_c   = amt_x[COUNT_BITS-1:0];

  always_comb begin
    flags.decl_bad   = (amt_x > total_x) || (amt_x < held_x);
    flags.over_need  = amt_x > need_x;
    flags.over_avail = amt_x > avail_x;
    flags.rel_bad    = (amt_x > held_x)
                    || (({1'b0, avail_x} + {1'b0, amt_x}) > MASK_X)
                    || (({1'b0, need_x} + {1'b0, amt_x}) > MASK_X);
    flags.need_fits  = WORK_W'(need_rd) <= work_r;
  end

  always_comb begin
    avail_nxt = avail_r;
    work_nxt  = work_r;
    held_nxt  = held_rd;
    need_nxt  = need_rd;
    wr_en     = 1'b0;
    case (cmd)
      LC_DECLARE: begin
        need_nxt = amt_c - held_rd;
        wr_en    = 1'b1;
      end
      LC_GRANT: begin
        avail_nxt = avail_r - amt_c;
        held_nxt  = held_rd + amt_c;
        need_nxt  = need_rd - amt_c;
        work_nxt  = WORK_W'(avail_nxt);
        wr_en     = 1'b1;
      end
      LC_ADD: begin
        work_nxt = work_r + WORK_W'(held_rd);
      end
      LC_RETURN: begin
        avail_nxt = avail_r + amt_c;
        held_nxt  = held_rd - amt_c;
        need_nxt  = need_rd + amt_c;
        wr_en     = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
    if (cfg_we) begin
      avail_nxt = cfg_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      avail_r <= '0;
      for (int i = 0; i < CUSTOMERS; i++) begin
        held_r[i] <= '0;
        need_r[i] <= '0;
      end
    end else begin
      avail_r <= avail_nxt;
      if (cfg_we) begin
        total_r <= cfg_val;
      end
      if (wr_en && idx_ok) begin
        held_r[rd_idx] <= held_nxt;
        need_r[rd_idx] <= need_nxt;
      end
    end
  end

  // work vector is set by each grant before the scan reads it
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

endmodule

>>> sv/bra_ctrl.sv
module bra_ctrl #(
  parameter int RESOURCE_TYPES = 5,
  parameter int CUSTOMERS      = 5,
  parameter int CI_W           = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [bra_pkg::OP_W-1:0]     in_op,
  input  logic [bra_pkg::CUST_W-1:0]   in_customer,
  output logic                         in_ready,
  output logic                         out_valid,
  output bra_pkg::status_t             out_status,
  input  logic                         out_ready,
  input  bra_pkg::lane_flags_t         lane_flags [RESOURCE_TYPES],
  output bra_pkg::lane_cmd_t           lane_cmd,
  output logic [CI_W-1:0]              rd_idx
);
  import bra_pkg::*;

  ctrl_state_t           state_r, state_nxt;
  logic [OP_W-1:0]       op_r;
  logic [CUST_W-1:0]     cust_r;
  logic [CI_W-1:0]       scan_r, scan_nxt;
  logic [CUSTOMERS-1:0]  done_r, done_nxt;
  logic                  progress_r, progress_nxt;
  status_t               status_r, status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [CI_W+CUST_W-1:0] cust_wide;
  logic [CI_W-1:0]       cust_idx;
  logic                  cust_ok, fits;
  logic                  any_decl_bad, any_over_need, any_over_avail, any_rel_bad, all_fit;

  assign cust_wide = {{CI_W{1'b0}}, cust_r};
  assign cust_idx  = cust_wide[CI_W-1:0];
  assign cust_ok   = 32'(cust_r) < 32'(CUSTOMERS);
  assign rd_idx    = (state_r == CS_SCAN) ? scan_r : cust_idx;

  // merge of the lane results
  always_comb begin
    any_decl_bad   = 1'b0;
    any_over_need  = 1'b0;
    any_over_avail = 1'b0;
    any_rel_bad    = 1'b0;
    all_fit        = 1'b1;
    for (int r = 0; r < RESOURCE_TYPES; r++) begin
      any_decl_bad   = any_decl_bad | lane_flags[r].decl_bad;
      any_over_need  = any_over_need | lane_flags[r].over_need;
      any_over_avail = any_over_avail | lane_flags[r].over_avail;
      any_rel_bad    = any_rel_bad | lane_flags[r].rel_bad;
      all_fit        = all_fit & lane_flags[r].need_fits;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    done_nxt       = done_r;
    progress_nxt   = progress_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    lane_cmd       = LC_IDLE;
    in_ready       = 1'b0;
    fits           = 1'b0;
    case (state_r)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = CS_CHECK;
        end
      end
      CS_CHECK: begin
        state_nxt = CS_DONE;
        status_nxt = STAT_RANGE;
        if (cust_ok) begin
          case (op_r)
            OP_DECLARE: begin
              if (!any_decl_bad) begin
                lane_cmd   = LC_DECLARE;
                status_nxt = STAT_OK;
              end
            end
            OP_REQUEST: begin
              if (any_over_need) begin
                status_nxt = STAT_RANGE;
              end else if (any_over_avail) begin
                status_nxt = STAT_UNSAFE;
              end else begin
                lane_cmd     = LC_GRANT;
                state_nxt    = CS_SCAN;
                scan_nxt     = '0;
                done_nxt     = '0;
                progress_nxt = 1'b0;
              end
            end
            OP_RELEASE: begin
              if (!any_rel_bad) begin
                lane_cmd   = LC_RETURN;
                status_nxt = STAT_OK;
              end
            end
            default: begin
              status_nxt = STAT_RANGE;
            end
          endcase
        end
      end
      CS_SCAN: begin
        fits = !done_r[scan_r] && all_fit;
        if (fits) begin
          lane_cmd         = LC_ADD;
          done_nxt[scan_r] = 1'b1;
        end
        progress_nxt = progress_r | fits;
        if (&done_nxt) begin
          status_nxt = STAT_OK;
          state_nxt  = CS_DONE;
        end else if (scan_r == CI_W'(CUSTOMERS - 1)) begin
          scan_nxt     = '0;
          progress_nxt = 1'b0;
          if (!(progress_r | fits)) begin
            state_nxt = CS_ROLLBACK;
          end
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      CS_ROLLBACK: begin
        lane_cmd   = LC_RETURN;
        status_nxt = STAT_UNSAFE;
        state_nxt  = CS_DONE;
      end
      CS_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          state_nxt      = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    done_r       <= done_nxt;
    progress_r   <= progress_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    if (in_valid && in_ready) begin
      op_r   <= in_op;
      cust_r <= in_customer;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

>>> sv/bankers_resource_allocator.sv
// channel | dir | words carried
// in_ch   | in  | op, customer, amount_0 .. amount_4
// out_ch  | out | status, one per input word
// cfg_ch  | in  | index, data: total of one resource type
//
// declare, release and refused requests finish without a scan; a granted request runs
// the safety scan, which visits one customer per cycle across all type lanes, and a
// failed scan adds a rollback step
// synchronous active-low reset clears the totals, available counts, holdings and needs to zero
// a waiting result does not block the next input word; a stalled output holds
// the following result until the register frees
`include "bankers_resource_allocator_macros.svh"

module bankers_resource_allocator #(
  parameter int RESOURCE_TYPES = 5,
  parameter int CUSTOMERS      = 5,
  parameter int COUNT_BITS     = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  bra_in_if.sink    in_ch,
  bra_out_if.source out_ch,
  bra_cfg_if.sink   cfg_ch
);
  import bra_pkg::*;

  localparam int CI_W   = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
  localparam int WORK_W = COUNT_BITS + $clog2(CUSTOMERS + 1);

  logic [AMT_W-1:0]          amt_r [NUM_AMOUNTS];
  logic [AMT_W-1:0]          lane_amt [RESOURCE_TYPES];
  logic [COUNT_BITS+CFG_DATA_W-1:0] cfg_wide;
  logic [COUNT_BITS-1:0]     cfg_val;
  logic [RESOURCE_TYPES-1:0] cfg_we;
  lane_flags_t               lane_flags [RESOURCE_TYPES];
  lane_cmd_t                 lane_cmd;
  logic [CI_W-1:0]           rd_idx;
  status_t                   out_status;
  logic                      in_acc;

  assign in_acc       = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_wide     = {{COUNT_BITS{1'b0}}, cfg_ch.data};
  assign cfg_val      = cfg_wide[COUNT_BITS-1:0];
  assign out_ch.status = out_status;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      amt_r[0] <= in_ch.amount_0;
      amt_r[1] <= in_ch.amount_1;
      amt_r[2] <= in_ch.amount_2;
      amt_r[3] <= in_ch.amount_3;
      amt_r[4] <= in_ch.amount_4;
    end
  end

  for (genvar r = 0; r < RESOURCE_TYPES; r++) begin : g_lane
    if (r < NUM_AMOUNTS) begin : g_fed
      assign lane_amt[r] = amt_r[r];
      assign cfg_we[r]   = cfg_ch.valid && (cfg_ch.index == CFG_IDX_W'(r));
    end else begin : g_unfed
      assign lane_amt[r] = '0;
      assign cfg_we[r]   = 1'b0;
    end

    bra_lane #(
      .CUSTOMERS  (CUSTOMERS),
      .COUNT_BITS (COUNT_BITS),
      .CI_W       (CI_W),
      .WORK_W     (WORK_W)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .cfg_we  (cfg_we[r]),
      .cfg_val (cfg_val),
      .amt     (lane_amt[r]),
      .cmd     (lane_cmd),
      .rd_idx  (rd_idx),
      .flags   (lane_flags[r])
    );
  end

  bra_ctrl #(
    .RESOURCE_TYPES (RESOURCE_TYPES),
    .CUSTOMERS      (CUSTOMERS),
    .CI_W           (CI_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_op       (in_ch.op),
    .in_customer (in_ch.customer),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_status  (out_status),
    .out_ready   (out_ch.ready),
    .lane_flags  (lane_flags),
    .lane_cmd    (lane_cmd),
    .rd_idx      (rd_idx)
  );

  `BRA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, !in_ch.ready)
  `BRA_ASSERT_IMP(a_idle_no_update, clk, rst_n, in_ch.ready, lane_cmd == LC_IDLE)
  `BRA_ASSERT_NXT(a_grant_scans, clk, rst_n, lane_cmd == LC_GRANT, lane_cmd != LC_GRANT && lane_cmd != LC_DECLARE && !in_ch.ready)

endmodule
